@@ rtl/armdp_pkg.sv @@
package armdp_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned InDataW   = 96;
  localparam int unsigned OutDataW  = 40;

  typedef enum logic [3:0] {
    OpAnd = 4'h0,
    OpEor = 4'h1,
    OpSub = 4'h2,
    OpRsb = 4'h3,
    OpAdd = 4'h4,
    OpAdc = 4'h5,
    OpSbc = 4'h6,
    OpRsc = 4'h7,
    OpTst = 4'h8,
    OpTeq = 4'h9,
    OpCmp = 4'ha,
    OpCmn = 4'hb,
    OpOrr = 4'hc,
    OpMov = 4'hd,
    OpBic = 4'he,
    OpMvn = 4'hf
  } alu_op_e;

  typedef enum logic [1:0] {
    ShLsl = 2'd0,
    ShLsr = 2'd1,
    ShAsr = 2'd2,
    ShRor = 2'd3
  } shift_type_e;

  // Shift amount that the immediate LSR and ASR forms encode as zero.
  localparam logic [7:0] FullShift = 8'd32;

  // The first member lands in the top bits, so result_value ends up in bits 31:0.
  typedef struct packed {
    logic             flags_written;
    logic             writes_dest;
    logic             flag_v;
    logic             flag_c;
    logic             flag_z;
    logic             flag_n;
    logic [WordW-1:0] result_value;
  } alu_res_t;

endpackage

@@ rtl/arm_data_processing_alu_shifter_unit.sv @@
// Execute stage for ARM-style data-processing instructions: the operand-two barrel
// shifter (rotated 8-bit immediate, or LSL/LSR/ASR/ROR/RRX by an immediate or by the
// low byte of a register) followed by the sixteen-opcode ALU with N Z C V flags.
// Each transaction on the input stream gives exactly one transaction on the output
// stream: it is held in the input register, then the shifter and the 32-bit adder
// evaluate in a single pass into the result register. A new instruction is taken in
// every cycle while the output side keeps up; the whole pipeline stalls only when both
// registers hold data and the output is not taken. Flags are computed even when the S
// bit is clear; flags_written tells the consumer whether to store them.
module arm_data_processing_alu_shifter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // alu_op[3:0], set_flags[4], immediate_form[5], operand_bits[17:6],
  // first_value[49:18], shifted_value[81:50], shift_reg_byte[89:82],
  // carry_in[90], overflow_in[91], zero fill[95:92]
  input  logic [armdp_pkg::InDataW-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // result_value[31:0], flag_n[32], flag_z[33], flag_c[34], flag_v[35],
  // writes_dest[36], flags_written[37], zero fill[39:38]
  output logic [armdp_pkg::OutDataW-1:0] m_axis_tdata
);
  import armdp_pkg::*;

  logic [InDataW-1:0] in_q;
  logic               in_vld_q;
  alu_res_t           res_d, res_q;
  logic               out_vld_q;
  logic               out_adv;
  logic               in_adv;

  // Unpacked input fields.
  alu_op_e            op;
  logic               set_flags;
  logic               imm_form;
  logic [11:0]        op_bits;
  logic [WordW-1:0]   a_val;
  logic [WordW-1:0]   rm_val;
  logic [7:0]         rs_byte;
  logic               cin;
  logic               vin;

  assign op        = alu_op_e'(in_q[3:0]);
  assign set_flags = in_q[4];
  assign imm_form  = in_q[5];
  assign op_bits   = in_q[17:6];
  assign a_val     = in_q[49:18];
  assign rm_val    = in_q[81:50];
  assign rs_byte   = in_q[89:82];
  assign cin       = in_q[90];
  assign vin       = in_q[91];

  assign out_adv       = !out_vld_q || m_axis_tready;
  assign in_adv        = !in_vld_q || out_adv;
  assign s_axis_tready = in_adv;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, res_q};

  // Operand two.
  logic [WordW-1:0]   op2;
  logic               sh_c;
  logic [4:0]         rot_amt;
  logic [2*WordW-1:0] rot_wide;
  logic [2*WordW-1:0] ror_wide;
  logic               by_reg;
  shift_type_e        sh_type;
  logic [7:0]         sh_amt;
  logic [WordW:0]     lsl_wide;
  logic [WordW:0]     lsr_wide;
  logic [WordW:0]     asr_wide;
  logic               sign;

  assign rot_amt  = {op_bits[11:8], 1'b0};
  assign rot_wide = {24'd0, op_bits[7:0], 24'd0, op_bits[7:0]} >> rot_amt;
  assign by_reg   = op_bits[4];
  assign sh_type  = shift_type_e'(op_bits[6:5]);
  assign sh_amt   = by_reg ? rs_byte : {3'd0, op_bits[11:7]};
  assign sign     = rm_val[WordW-1];
  assign lsl_wide = {1'b0, rm_val} << sh_amt[4:0];
  assign lsr_wide = {rm_val, 1'b0} >> sh_amt[4:0];
  assign asr_wide = $signed({rm_val, 1'b0}) >>> sh_amt[4:0];
  assign ror_wide = {rm_val, rm_val} >> sh_amt[4:0];

  always_comb begin
    logic [7:0] amt_e;
    amt_e = sh_amt;
    op2   = rm_val;
    sh_c  = cin;
    if (imm_form) begin
      op2  = rot_wide[WordW-1:0];
      sh_c = (rot_amt != 5'd0) ? op2[WordW-1] : cin;
    end else if (sh_amt == 8'd0 && (by_reg || sh_type == ShLsl)) begin
      op2  = rm_val;
      sh_c = cin;
    end else if (sh_amt == 8'd0 && sh_type == ShRor) begin
      op2  = {cin, rm_val[WordW-1:1]};
      sh_c = rm_val[0];
    end else begin
      // The immediate LSR and ASR forms encode a shift by 32 as zero.
      if (sh_amt == 8'd0) begin
        amt_e = FullShift;
      end
      case (sh_type)
        ShLsl: begin
          if (amt_e < FullShift) begin
            op2  = lsl_wide[WordW-1:0];
            sh_c = lsl_wide[WordW];
          end else begin
            op2  = '0;
            sh_c = (amt_e == FullShift) ? rm_val[0] : 1'b0;
          end
        end
        ShLsr: begin
          if (amt_e < FullShift) begin
            op2  = lsr_wide[WordW:1];
            sh_c = lsr_wide[0];
          end else begin
            op2  = '0;
            sh_c = (amt_e == FullShift) ? sign : 1'b0;
          end
        end
        ShAsr: begin
          if (amt_e < FullShift) begin
            op2  = asr_wide[WordW:1];
            sh_c = asr_wide[0];
          end else begin
            op2  = {WordW{sign}};
            sh_c = sign;
          end
        end
        default: begin
          if (amt_e[4:0] == 5'd0) begin
            op2  = rm_val;
            sh_c = sign;
          end else begin
            op2  = ror_wide[WordW-1:0];
            sh_c = op2[WordW-1];
          end
        end
      endcase
    end
  end

  // ALU.
  logic [WordW-1:0] add_x, add_y, logic_res, res_val;
  logic             add_cy, arith;
  logic [WordW:0]   sum;

  always_comb begin
    add_x     = a_val;
    add_y     = op2;
    add_cy    = 1'b0;
    arith     = 1'b0;
    logic_res = op2;
    case (op)
      OpAnd, OpTst: logic_res = a_val & op2;
      OpEor, OpTeq: logic_res = a_val ^ op2;
      OpSub, OpCmp: begin
        add_y = ~op2; add_cy = 1'b1; arith = 1'b1;
      end
      OpRsb: begin
        add_x = op2; add_y = ~a_val; add_cy = 1'b1; arith = 1'b1;
      end
      OpAdd, OpCmn: arith = 1'b1;
      OpAdc: begin
        add_cy = cin; arith = 1'b1;
      end
      OpSbc: begin
        add_y = ~op2; add_cy = cin; arith = 1'b1;
      end
      OpRsc: begin
        add_x = op2; add_y = ~a_val; add_cy = cin; arith = 1'b1;
      end
      OpOrr: logic_res = a_val | op2;
      OpMov: logic_res = op2;
      OpBic: logic_res = a_val & ~op2;
      default: logic_res = ~op2;
    endcase
  end

  assign sum     = {1'b0, add_x} + {1'b0, add_y} + {{WordW{1'b0}}, add_cy};
  assign res_val = arith ? sum[WordW-1:0] : logic_res;

  always_comb begin
    res_d.result_value  = res_val;
    res_d.flag_n        = res_val[WordW-1];
    res_d.flag_z        = (res_val == '0);
    res_d.flag_c        = arith ? sum[WordW] : sh_c;
    res_d.flag_v        = arith ? ((add_x[WordW-1] ^ res_val[WordW-1]) &
                                   (add_y[WordW-1] ^ res_val[WordW-1])) : vin;
    res_d.writes_dest   = (op[3:2] != 2'b10);
    res_d.flags_written = set_flags;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_adv) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (out_adv) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && s_axis_tvalid) begin
      in_q <= s_axis_tdata;
    end
    if (out_adv && in_vld_q) begin
      res_q <= res_d;
    end
  end

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && out_adv |=> m_axis_tvalid)
    else $error("instruction in the input register was lost");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> s_axis_tready)
    else $error("input stalled with an empty input register");

  a_flag_n: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[32] == m_axis_tdata[31])
    else $error("N flag does not match result sign");

  a_flag_z: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[33] == (m_axis_tdata[31:0] == 32'd0))
    else $error("Z flag does not match result");

endmodule
